// ----- rtl/scs_pkg.sv -----
// Shared types, character codes and result helpers for the script comment stripper.
`default_nettype none

package scs_pkg;

  localparam int unsigned MAX_LEVEL_DEF = 15;
  localparam int unsigned QUEUE_DEPTH   = 4;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_COMMENT = 2'd1;
  localparam logic [1:0] ERR_STRING  = 2'd2;
  localparam logic [1:0] ERR_BRACKET = 2'd3;

  localparam logic [7:0] CH_DASH   = 8'h2d;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_EQUAL  = 8'h3d;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_stream;
    logic [1:0] error_code;
  } out_item_t;

  // Up to two results produced by one accepted input item.
  typedef struct packed {
    logic [1:0]            cnt;
    out_item_t [1:0]       item;
  } push_t;

  // Append one emitted byte to the result pair.
  function automatic push_t put_byte(push_t p, logic [7:0] b);
    push_t r;
    r = p;
    if (p.cnt == 2'd0) begin
      r.item[0].out_byte   = b;
      r.item[0].byte_valid = 1'b1;
      r.cnt                = 2'd1;
    end else if (p.cnt == 2'd1) begin
      r.item[1].out_byte   = b;
      r.item[1].byte_valid = 1'b1;
      r.cnt                = 2'd2;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/scs_front.sv -----
// Front end: accepts source bytes, runs the lexer state and emits up to two results per item.
`default_nettype none

module scs_front #(
  parameter int unsigned MaxLevel = scs_pkg::MAX_LEVEL_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             room_i,
  input  wire scs_pkg::in_item_t in_item_i,
  output scs_pkg::push_t        push_o
);

  import scs_pkg::*;

  localparam int unsigned LW = $clog2(MaxLevel + 1);

  localparam logic [3:0] M_CODE       = 4'd0;
  localparam logic [3:0] M_DASH       = 4'd1;
  localparam logic [3:0] M_LBRACK     = 4'd2;
  localparam logic [3:0] M_LSTR_OPEN  = 4'd3;
  localparam logic [3:0] M_LSTR       = 4'd4;
  localparam logic [3:0] M_LSTR_CLOSE = 4'd5;
  localparam logic [3:0] M_QSTR       = 4'd6;
  localparam logic [3:0] M_CMT_START  = 4'd7;
  localparam logic [3:0] M_CMT_OPEN   = 4'd8;
  localparam logic [3:0] M_LCMT       = 4'd9;
  localparam logic [3:0] M_LCMT_CLOSE = 4'd10;
  localparam logic [3:0] M_LINE_CMT   = 4'd11;

  logic [3:0]    mode_q, mode_d;
  logic          line_q, line_d;
  logic          dq_q, dq_d;
  logic          bs_q, bs_d;
  logic [LW-1:0] lvl_q, lvl_d;
  logic [LW-1:0] cc_q, cc_d;
  logic [1:0]    err_q, err_d;
  logic          accept;

  assign accept = in_valid_i && room_i;

  always_comb begin
    logic [7:0] c;
    logic       last;
    logic       run_code;
    push_t      p;

    c        = in_item_i.in_byte;
    last     = in_item_i.is_last;
    run_code = 1'b0;
    p        = '0;
    mode_d   = mode_q;
    line_d   = line_q;
    dq_d     = dq_q;
    bs_d     = bs_q;
    lvl_d    = lvl_q;
    cc_d     = cc_q;
    err_d    = err_q;

    if (err_q == ERR_NONE) begin
      unique case (mode_q)
        M_DASH: begin
          if (c == CH_DASH) begin
            mode_d = M_CMT_START;
          end else begin
            p        = put_byte(p, CH_DASH);
            run_code = 1'b1;
          end
        end
        M_LBRACK: begin
          if (c == CH_LBRACK) begin
            p      = put_byte(p, CH_LBRACK);
            p      = put_byte(p, CH_LBRACK);
            lvl_d  = '0;
            mode_d = M_LSTR;
          end else if (c == CH_EQUAL) begin
            // first level always fits, the limit is at least one
            lvl_d  = LW'(1);
            p      = put_byte(p, CH_LBRACK);
            p      = put_byte(p, CH_EQUAL);
            mode_d = M_LSTR_OPEN;
          end else begin
            p        = put_byte(p, CH_LBRACK);
            run_code = 1'b1;
          end
        end
        M_LSTR_OPEN: begin
          if (c == CH_EQUAL) begin
            if (lvl_q >= LW'(MaxLevel)) begin
              err_d = ERR_BRACKET;
            end else begin
              lvl_d = lvl_q + LW'(1);
              p     = put_byte(p, c);
            end
          end else if (c == CH_LBRACK) begin
            p      = put_byte(p, c);
            mode_d = M_LSTR;
          end else begin
            err_d = ERR_BRACKET;
          end
        end
        M_LSTR: begin
          p = put_byte(p, c);
          if (c == CH_RBRACK) begin
            cc_d   = '0;
            mode_d = M_LSTR_CLOSE;
          end
        end
        M_LSTR_CLOSE: begin
          p = put_byte(p, c);
          if (c == CH_RBRACK) begin
            cc_d = '0;
            if (cc_q == lvl_q) begin
              mode_d = M_CODE;
            end
          end else if (c == CH_EQUAL && cc_q < lvl_q) begin
            cc_d = cc_q + LW'(1);
          end else begin
            mode_d = M_LSTR;
          end
        end
        M_QSTR: begin
          p = put_byte(p, c);
          if (bs_q) begin
            bs_d = 1'b0;
          end else if (c == CH_BSLASH) begin
            bs_d = 1'b1;
          end else if (c == (dq_q ? CH_DQUOTE : CH_SQUOTE)) begin
            mode_d = M_CODE;
          end
        end
        M_CMT_START, M_CMT_OPEN: begin
          if (c == CH_LBRACK && mode_q == M_CMT_START) begin
            lvl_d  = '0;
            mode_d = M_CMT_OPEN;
          end else if (c == CH_EQUAL && mode_q == M_CMT_OPEN) begin
            if (lvl_q >= LW'(MaxLevel)) begin
              err_d = ERR_BRACKET;
            end else begin
              lvl_d = lvl_q + LW'(1);
            end
          end else if (c == CH_LBRACK) begin
            mode_d = M_LCMT;
          end else if (c == CH_LF) begin
            p      = put_byte(p, c);
            line_d = 1'b1;
            mode_d = M_CODE;
          end else begin
            mode_d = M_LINE_CMT;
          end
        end
        M_LCMT: begin
          if (c == CH_LF) begin
            p = put_byte(p, c);
          end else if (c == CH_RBRACK) begin
            cc_d   = '0;
            mode_d = M_LCMT_CLOSE;
          end
        end
        M_LCMT_CLOSE: begin
          if (c == CH_RBRACK) begin
            if (cc_q == lvl_q) begin
              mode_d = M_CODE;
            end
            cc_d = '0;
          end else if (c == CH_EQUAL && cc_q < lvl_q) begin
            cc_d = cc_q + LW'(1);
          end else begin
            if (c == CH_LF) begin
              p = put_byte(p, c);
            end
            mode_d = M_LCMT;
          end
        end
        M_LINE_CMT: begin
          if (c == CH_LF) begin
            p      = put_byte(p, c);
            line_d = 1'b1;
            mode_d = M_CODE;
          end
        end
        default: begin
          run_code = 1'b1;
        end
      endcase

      // plain code byte, also reached when a held dash or bracket is released
      if (run_code) begin
        mode_d = M_CODE;
        if (!(line_q && (c == CH_SPACE || c == CH_TAB || c == CH_CR))) begin
          line_d = 1'b0;
          if (c == CH_CR) begin
            line_d = 1'b0;
          end else if (c == CH_LF) begin
            p      = put_byte(p, c);
            line_d = 1'b1;
          end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
            p      = put_byte(p, c);
            dq_d   = (c == CH_DQUOTE);
            bs_d   = 1'b0;
            mode_d = M_QSTR;
          end else if (c == CH_DASH && !last) begin
            mode_d = M_DASH;
          end else if (c == CH_LBRACK && !last) begin
            mode_d = M_LBRACK;
          end else begin
            p = put_byte(p, c);
          end
        end
      end
    end

    if (last) begin
      if (err_d == ERR_NONE) begin
        priority case (mode_d)
          M_LSTR_OPEN, M_LSTR, M_LSTR_CLOSE, M_QSTR: err_d = ERR_STRING;
          M_LCMT, M_LCMT_CLOSE:                      err_d = ERR_COMMENT;
          M_DASH:                                    p = put_byte(p, CH_DASH);
          M_LBRACK:                                  p = put_byte(p, CH_LBRACK);
          default: ;
        endcase
      end
      // bare end marker when nothing else was emitted
      if (p.cnt == 2'd0) begin
        p.cnt = 2'd1;
      end
      if (p.cnt == 2'd1) begin
        p.item[0].end_of_stream = 1'b1;
      end else begin
        p.item[1].end_of_stream = 1'b1;
      end
    end

    p.item[0].error_code = err_d;
    p.item[1].error_code = err_d;

    // return to the reset state for the next source
    if (last) begin
      mode_d = M_CODE;
      line_d = 1'b1;
      dq_d   = 1'b0;
      bs_d   = 1'b0;
      lvl_d  = '0;
      cc_d   = '0;
      err_d  = ERR_NONE;
    end

    if (!accept) begin
      p.cnt = 2'd0;
    end
    push_o = p;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_CODE;
      line_q <= 1'b1;
      dq_q   <= 1'b0;
      bs_q   <= 1'b0;
      lvl_q  <= '0;
      cc_q   <= '0;
      err_q  <= ERR_NONE;
    end else if (accept) begin
      mode_q <= mode_d;
      line_q <= line_d;
      dq_q   <= dq_d;
      bs_q   <= bs_d;
      lvl_q  <= lvl_d;
      cc_q   <= cc_d;
      err_q  <= err_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/scs_queue.sv -----
// Back end: result queue taking up to two items per cycle and presenting one per cycle while out_ready_i is high.
`default_nettype none

module scs_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire scs_pkg::push_t    push_i,
  output logic                   room_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output scs_pkg::out_item_t     out_item_o
);

  import scs_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  out_item_t         mem_q [QUEUE_DEPTH];
  logic [PW-1:0]     wr_q, wr_d;
  logic [PW-1:0]     rd_q, rd_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              pop;

  assign room_o      = (cnt_q <= CW'(QUEUE_DEPTH - 2));
  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_d  = wr_q + PW'(push_i.cnt);
    rd_d  = rd_q + PW'(pop);
    cnt_d = cnt_q + CW'(push_i.cnt) - CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.item[0];
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_q + PW'(1)] <= push_i.item[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/script_comment_stripper.sv -----
// Top level of the script comment stripper: lexer front end and result queue.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+---------------------------
//   input   | in        | in_valid_i / in_ready_o    | in_item_i  (in_byte, is_last)
//   output  | out       | out_valid_o / out_ready_i  | out_item_o (out_byte, byte_valid,
//           |           |                            |   end_of_stream, error_code)
//
// One source byte is taken per cycle while in_ready_o is high; the lexer state updates in the same cycle and
// its zero to two results land in a four-entry queue, read out one item per cycle while out_ready_i is high.
// A result is registered into the queue when its byte is accepted and leaves once the items ahead of it are out.
// Input is taken while the queue has two free entries, so the input stalls once three
// or more items wait, from an output stall or from bytes that yield two results.
// Reset clears the lexer state and queue.
`default_nettype none

module script_comment_stripper #(
  parameter int unsigned MaxLevel = scs_pkg::MAX_LEVEL_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire scs_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output scs_pkg::out_item_t      out_item_o
);

  import scs_pkg::*;

  push_t push;
  logic  room;

  assign in_ready_o = room;

  scs_front #(
    .MaxLevel(MaxLevel)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .room_i    (room),
    .in_item_i (in_item_i),
    .push_o    (push)
  );

  scs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

// ----- tb/scs_checker.sv -----
// Checker for the script comment stripper: predicts the cleaned stream and compares results.
`timescale 1ns / 1ps

module scs_checker
  import scs_pkg::*;
#(
  parameter int unsigned MaxLevel = MAX_LEVEL_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_item_i,
  output int        fails_o,
  output int        pending_o
);

  typedef enum logic [3:0] {
    LX_CODE, LX_DASH, LX_LBRACK, LX_LSTR_OPEN, LX_LSTR, LX_LSTR_CLOSE, LX_QSTR,
    LX_CMT_START, LX_CMT_OPEN, LX_LCMT, LX_LCMT_CLOSE, LX_LINE_CMT
  } lex_mode_e;

  lex_mode_e   mode;
  logic        line_start;
  logic        dquote;
  logic        escaped;
  int unsigned level;
  int unsigned close_cnt;
  logic [1:0]  err;

  out_item_t   step_out [2];
  int          step_n;
  out_item_t   cleaned_q [$];
  out_item_t   want;
  int          fails;

  task automatic clear_lexer();
    mode       = LX_CODE;
    line_start = 1'b1;
    dquote     = 1'b0;
    escaped    = 1'b0;
    level      = 0;
    close_cnt  = 0;
    err        = ERR_NONE;
  endtask

  task automatic emit(input logic [7:0] c);
    if (step_n < 2) begin
      step_out[step_n] = '{c, 1'b1, 1'b0, ERR_NONE};
      step_n++;
    end
  endtask

  task automatic deepen();
    if (level >= MaxLevel) err = ERR_BRACKET;
    else level++;
  endtask

  task automatic lex_code(input logic [7:0] c, input logic last);
    mode = LX_CODE;
    // leading blanks of a line vanish
    if (!(line_start && (c == CH_SPACE || c == CH_TAB || c == CH_CR))) begin
      line_start = 1'b0;
      if (c != CH_CR) begin
        if (c == CH_LF) begin
          emit(c);
          line_start = 1'b1;
        end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
          emit(c);
          dquote  = (c == CH_DQUOTE);
          escaped = 1'b0;
          mode    = LX_QSTR;
        end else if (c == CH_DASH && !last) begin
          mode = LX_DASH;
        end else if (c == CH_LBRACK && !last) begin
          mode = LX_LBRACK;
        end else begin
          emit(c);
        end
      end
    end
  endtask

  task automatic lex_byte(input logic [7:0] c, input logic last);
    case (mode)
      LX_DASH: begin
        if (c == CH_DASH) begin
          mode = LX_CMT_START;
        end else begin
          emit(CH_DASH);
          lex_code(c, last);
        end
      end
      LX_LBRACK: begin
        if (c == CH_LBRACK) begin
          emit(CH_LBRACK);
          emit(CH_LBRACK);
          level = 0;
          mode  = LX_LSTR;
        end else if (c == CH_EQUAL) begin
          level = 0;
          deepen();
          emit(CH_LBRACK);
          emit(CH_EQUAL);
          mode = LX_LSTR_OPEN;
        end else begin
          emit(CH_LBRACK);
          lex_code(c, last);
        end
      end
      LX_LSTR_OPEN: begin
        if (c == CH_EQUAL) begin
          deepen();
          if (err == ERR_NONE) emit(c);
        end else if (c == CH_LBRACK) begin
          emit(c);
          mode = LX_LSTR;
        end else begin
          err = ERR_BRACKET;
        end
      end
      LX_LSTR: begin
        emit(c);
        if (c == CH_RBRACK) begin
          close_cnt = 0;
          mode      = LX_LSTR_CLOSE;
        end
      end
      LX_LSTR_CLOSE: begin
        emit(c);
        if (c == CH_RBRACK) begin
          if (close_cnt == level) mode = LX_CODE;
          close_cnt = 0;
        end else if (c == CH_EQUAL && close_cnt < level) begin
          close_cnt++;
        end else begin
          mode = LX_LSTR;
        end
      end
      LX_QSTR: begin
        emit(c);
        if (escaped) escaped = 1'b0;
        else if (c == CH_BSLASH) escaped = 1'b1;
        else if (c == (dquote ? CH_DQUOTE : CH_SQUOTE)) mode = LX_CODE;
      end
      LX_CMT_START, LX_CMT_OPEN: begin
        if (c == CH_LBRACK && mode == LX_CMT_START) begin
          level = 0;
          mode  = LX_CMT_OPEN;
        end else if (c == CH_EQUAL && mode == LX_CMT_OPEN) begin
          deepen();
        end else if (c == CH_LBRACK) begin
          mode = LX_LCMT;
        end else if (c == CH_LF) begin
          emit(c);
          line_start = 1'b1;
          mode       = LX_CODE;
        end else begin
          mode = LX_LINE_CMT;
        end
      end
      LX_LCMT: begin
        if (c == CH_LF) begin
          emit(c);
        end else if (c == CH_RBRACK) begin
          close_cnt = 0;
          mode      = LX_LCMT_CLOSE;
        end
      end
      LX_LCMT_CLOSE: begin
        if (c == CH_RBRACK) begin
          if (close_cnt == level) mode = LX_CODE;
          close_cnt = 0;
        end else if (c == CH_EQUAL && close_cnt < level) begin
          close_cnt++;
        end else begin
          if (c == CH_LF) emit(c);
          mode = LX_LCMT;
        end
      end
      LX_LINE_CMT: begin
        if (c == CH_LF) begin
          emit(c);
          line_start = 1'b1;
          mode       = LX_CODE;
        end
      end
      default: lex_code(c, last);
    endcase
  endtask

  // Work out the results of one accepted item and queue them.
  task automatic predict_item(input in_item_t it);
    step_n = 0;
    if (err == ERR_NONE) lex_byte(it.in_byte, it.is_last);
    if (it.is_last) begin
      if (err == ERR_NONE) begin
        case (mode)
          LX_LSTR_OPEN, LX_LSTR, LX_LSTR_CLOSE, LX_QSTR: err = ERR_STRING;
          LX_LCMT, LX_LCMT_CLOSE: err = ERR_COMMENT;
          LX_DASH: emit(CH_DASH);
          LX_LBRACK: emit(CH_LBRACK);
          default: ;
        endcase
      end
      if (step_n == 0) begin
        step_out[0] = '{8'h00, 1'b0, 1'b0, ERR_NONE};
        step_n      = 1;
      end
      step_out[step_n - 1].end_of_stream = 1'b1;
    end
    for (int k = 0; k < step_n; k++) begin
      step_out[k].error_code = err;
      cleaned_q.push_back(step_out[k]);
    end
    if (it.is_last) clear_lexer();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_lexer();
      cleaned_q.delete();
      fails     = 0;
      fails_o   <= 0;
      pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) predict_item(in_item_i);
      if (out_valid_i && out_ready_i) begin
        if (cleaned_q.size() == 0) begin
          if (fails < 10)
            $display("unexpected item: byte=%02h valid=%0b eos=%0b err=%0d",
                     out_item_i.out_byte, out_item_i.byte_valid,
                     out_item_i.end_of_stream, out_item_i.error_code);
          fails++;
        end else begin
          want = cleaned_q.pop_front();
          if (out_item_i.out_byte !== want.out_byte ||
              out_item_i.byte_valid !== want.byte_valid ||
              out_item_i.end_of_stream !== want.end_of_stream ||
              out_item_i.error_code !== want.error_code) begin
            if (fails < 10)
              $display({"mismatch at %0t: expected byte=%02h valid=%0b eos=%0b err=%0d,",
                        " got byte=%02h valid=%0b eos=%0b err=%0d"}, $realtime,
                       want.out_byte, want.byte_valid, want.end_of_stream,
                       want.error_code, out_item_i.out_byte, out_item_i.byte_valid,
                       out_item_i.end_of_stream, out_item_i.error_code);
            fails++;
          end
        end
      end
      fails_o   <= fails;
      pending_o <= cleaned_q.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for the script comment stripper: Lua-like byte streams, stalls, verdict.
`timescale 1ns / 1ps

module tb_top;
  import scs_pkg::*;

  localparam int RandomItems   = 1050;
  localparam int WatchdogLimit = 2000;
  localparam int TailCycles    = 20;
  localparam string TxtChars   = "abcdefghxyz0123456789_+*/(){}.,;:<>#~ ";

  typedef enum logic [1:0] {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_PERIODIC} rdy_mode_e;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  int        fails;
  int        pending;
  int        idle_cnt  = 0;
  int        burst_left = 0;
  int        random_items = 0;
  rdy_mode_e rdy_mode  = RDY_ALWAYS;
  int        rdy_left  = 0;
  logic [7:0] src [$];

  always #5 clk_i = ~clk_i;

  script_comment_stripper uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o)
  );

  scs_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_i  (out_item_o),
    .fails_o     (fails),
    .pending_o   (pending)
  );

  // Receiver: switch between stall patterns whenever a random countdown runs out.
  always @(posedge clk_i) begin
    if (rdy_left == 0) begin
      rdy_mode <= rdy_mode_e'($urandom_range(0, 3));
      rdy_left <= $urandom_range(20, 300);
    end else begin
      rdy_left <= rdy_left - 1;
    end
    case (rdy_mode)
      RDY_ALWAYS:   out_ready <= 1'b1;
      RDY_HALF:     out_ready <= ($urandom_range(0, 1) == 1);
      RDY_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
      default:      out_ready <= (rdy_left % 5 != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [7:0] pick(input string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) src.push_back(s[i]);
  endtask

  task automatic add_rep(input logic [7:0] c, input int n);
    for (int i = 0; i < n; i++) src.push_back(c);
  endtask

  task automatic add_fill(input int n, input logic with_lf);
    for (int i = 0; i < n; i++) begin
      if (with_lf && $urandom_range(0, 7) == 0) src.push_back(CH_LF);
      else src.push_back(pick(TxtChars));
    end
  endtask

  function automatic int pick_level();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, MAX_LEVEL_DEF) : $urandom_range(0, 3);
  endfunction

  // Body of a long bracket: text, newlines and closers of the wrong level.
  task automatic add_long_body(input int lvl);
    int chunks;
    chunks = $urandom_range(0, 4);
    for (int i = 0; i < chunks; i++) begin
      if ($urandom_range(0, 2) == 0) begin
        src.push_back(CH_RBRACK);
        if (lvl > 0 && $urandom_range(0, 1) == 0) add_rep(CH_EQUAL, $urandom_range(0, lvl - 1));
        else add_rep(CH_EQUAL, lvl + 1);
        src.push_back(CH_RBRACK);
      end
      add_fill($urandom_range(1, 6), 1'b1);
    end
  endtask

  task automatic add_fragment(output logic broken);
    int roll;
    int lvl;
    logic [7:0] q;
    broken = 1'b0;
    roll   = $urandom_range(0, 99);
    if (roll < 22) begin
      add_fill($urandom_range(1, 8), 1'b0);
      if ($urandom_range(0, 2) == 0) begin
        src.push_back(CH_DASH);
        add_fill(1, 1'b0);
      end else if ($urandom_range(0, 2) == 0) begin
        src.push_back(CH_LBRACK);
        add_fill($urandom_range(1, 2), 1'b0);
        src.push_back(CH_RBRACK);
      end
    end else if (roll < 34) begin
      if ($urandom_range(0, 3) != 0) src.push_back(CH_LF);
      for (int i = $urandom_range(0, 3); i > 0; i--) begin
        case ($urandom_range(0, 2))
          0:       src.push_back(CH_SPACE);
          1:       src.push_back(CH_TAB);
          default: src.push_back(CH_CR);
        endcase
      end
    end else if (roll < 48) begin
      q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
      src.push_back(q);
      for (int i = $urandom_range(0, 6); i > 0; i--) begin
        case ($urandom_range(0, 4))
          0: begin
            src.push_back(CH_BSLASH);
            case ($urandom_range(0, 3))
              0:       src.push_back(q);
              1:       src.push_back(CH_BSLASH);
              2:       src.push_back(CH_LF);
              default: src.push_back(pick("nt'\""));
            endcase
          end
          1:       src.push_back(q == CH_DQUOTE ? CH_SQUOTE : CH_DQUOTE);
          2:       src.push_back(CH_CR);
          default: add_fill($urandom_range(1, 4), 1'b1);
        endcase
      end
      src.push_back(q);
    end else if (roll < 60) begin
      lvl = pick_level();
      src.push_back(CH_LBRACK);
      add_rep(CH_EQUAL, lvl);
      src.push_back(CH_LBRACK);
      add_long_body(lvl);
      src.push_back(CH_RBRACK);
      add_rep(CH_EQUAL, lvl);
      src.push_back(CH_RBRACK);
    end else if (roll < 72) begin
      add_text("--");
      case ($urandom_range(0, 4))
        0:       add_text("[");
        1:       add_text("[=");
        2:       add_text("=");
        default: ;
      endcase
      add_fill($urandom_range(0, 8), 1'b0);
      if ($urandom_range(0, 4) != 0) src.push_back(CH_LF);
    end else if (roll < 84) begin
      lvl = pick_level();
      add_text("--[");
      add_rep(CH_EQUAL, lvl);
      src.push_back(CH_LBRACK);
      add_long_body(lvl);
      src.push_back(CH_RBRACK);
      add_rep(CH_EQUAL, lvl);
      src.push_back(CH_RBRACK);
    end else if (roll < 93) begin
      for (int i = $urandom_range(1, 6); i > 0; i--) src.push_back($urandom_range(0, 255));
    end else begin
      // malformed or too deep bracket: the rest of the source would be ignored
      broken = 1'b1;
      case ($urandom_range(0, 2))
        0: begin
          src.push_back(CH_LBRACK);
          add_rep(CH_EQUAL, $urandom_range(1, 3));
          src.push_back(pick(TxtChars));
        end
        1: begin
          src.push_back(CH_LBRACK);
          add_rep(CH_EQUAL, MAX_LEVEL_DEF + 1);
          src.push_back(CH_LBRACK);
        end
        default: begin
          add_text("--[");
          add_rep(CH_EQUAL, $urandom_range(MAX_LEVEL_DEF + 1, MAX_LEVEL_DEF + 2));
          src.push_back(CH_LBRACK);
        end
      endcase
    end
  endtask

  task automatic build_source();
    int target;
    int cut;
    logic broken;
    if ($urandom_range(0, 19) == 0) begin
      src.push_back($urandom_range(0, 255));
    end else begin
      target = $urandom_range(4, 60);
      broken = 1'b0;
      while (src.size() < target && !broken) add_fragment(broken);
      // end some sources early, inside whatever was open
      if ($urandom_range(0, 5) == 0) begin
        cut = $urandom_range(1, src.size());
        while (src.size() > cut) void'(src.pop_back());
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) gap = 0;
      else if ($urandom_range(0, 9) == 0) gap = $urandom_range(8, 25);
      else gap = $urandom_range(1, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= '{b, last};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_source();
    for (int i = 0; i < src.size(); i++) send_byte(src[i], i == src.size() - 1);
    src.delete();
  endtask

  // Hold the input until every expected item has left the block.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    logic paused;
    paused = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src.push_back(8'h00);
    src.push_back(8'hff);
    send_source();
    add_text("-");
    send_source();
    add_text("[");
    send_source();
    add_text("--[x");
    send_source();
    add_text("[=x");
    send_source();
    add_text("'a");
    send_source();
    add_text("--[[");
    send_source();
    add_text(" ");
    src.push_back(CH_CR);
    add_text("-a");
    send_source();
    add_text("[[]]");
    send_source();
    drain();

    while (random_items < RandomItems) begin
      build_source();
      random_items += src.size();
      send_source();
      if (!paused && random_items >= RandomItems / 2) begin
        drain();
        paused = 1'b1;
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (fails == 0 && pending == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
